>>> rtl/pbdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdt_pkg
// Shared types, codes and sizes of the port binding demultiplexing table.
// ----------------------------------------------------------------------------
package pbdt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int NUM_PROTO     = 256;

    localparam logic [2:0] FUNC_BIND   = 3'd0;
    localparam logic [2:0] FUNC_AUTO   = 3'd1;
    localparam logic [2:0] FUNC_REBIND = 3'd2;
    localparam logic [2:0] FUNC_LOOKUP = 3'd3;
    localparam logic [2:0] FUNC_UNBIND = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IN_USE    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] REG_MIN_PORT = 2'd0;
    localparam logic [1:0] REG_WC_PORT  = 2'd1;
    localparam logic [1:0] REG_WC_ADDR  = 2'd2;

    typedef enum logic [2:0] {
        OP_BIND, OP_AUTO, OP_REBIND, OP_LOOKUP, OP_UNBIND, OP_NONE
    } t_op;

    typedef struct packed {
        logic [7:0]  proto;
        logic [15:0] lport;
        logic [31:0] laddr;
        logic [15:0] rport;
        logic [31:0] raddr;
    } t_key;

    localparam int KV_W = $bits(t_key) + 16;

    typedef struct packed {
        t_op         op;
        t_key        key;
        logic [15:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [15:0] min_port;
        logic [15:0] wc_port;
        logic [31:0] wc_addr;
    } t_cfg;

endpackage

>>> rtl/pbdt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdt_req_if / pbdt_rsp_if
// Valid/ready channels for requests into and results out of the table.
// ----------------------------------------------------------------------------
interface pbdt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [7:0]  proto;
    logic [15:0] lcl_port;
    logic [31:0] local_addr;
    logic [15:0] rmt_port;
    logic [31:0] remote_addr;
    logic [15:0] handle;

    modport source (output valid, func, proto, lcl_port, local_addr, rmt_port,
                    remote_addr, handle, input ready);
    modport sink   (input valid, func, proto, lcl_port, local_addr, rmt_port,
                    remote_addr, handle, output ready);
endinterface

interface pbdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] found_handle;
    logic [15:0] assigned_port;

    modport source (output valid, status, found_handle, assigned_port, input ready);
    modport sink   (input valid, status, found_handle, assigned_port, output ready);
endinterface

>>> rtl/pbdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/pbdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdt_front
// Accepts requests, decodes the function code and queues up to two commands.
// ----------------------------------------------------------------------------
module pbdt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pbdt_req_if.sink        i_req,
    output logic            o_cmd_valid,
    output pbdt_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_ready
);
    pbdt_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    pbdt_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.key.proto = i_req.proto;
        w_cmd.key.lport = i_req.lcl_port;
        w_cmd.key.laddr = i_req.local_addr;
        w_cmd.key.rport = i_req.rmt_port;
        w_cmd.key.raddr = i_req.remote_addr;
        w_cmd.handle    = i_req.handle;
        unique case (i_req.func)
            pbdt_pkg::FUNC_BIND:   w_cmd.op = pbdt_pkg::OP_BIND;
            pbdt_pkg::FUNC_AUTO:   w_cmd.op = pbdt_pkg::OP_AUTO;
            pbdt_pkg::FUNC_REBIND: w_cmd.op = pbdt_pkg::OP_REBIND;
            pbdt_pkg::FUNC_LOOKUP: w_cmd.op = pbdt_pkg::OP_LOOKUP;
            pbdt_pkg::FUNC_UNBIND: w_cmd.op = pbdt_pkg::OP_UNBIND;
            default:               w_cmd.op = pbdt_pkg::OP_NONE;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

>>> rtl/pbdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbdt_back
// Executes commands: scans the binding memory, updates it, issues results.
// ----------------------------------------------------------------------------
module pbdt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  pbdt_pkg::t_cmd  i_cmd,
    output logic            o_cmd_ready,
    input  pbdt_pkg::t_cfg  i_cfg,
    pbdt_rsp_if.source      o_rsp
);
    localparam int IW = pbdt_pkg::IDX_W;
    localparam logic [IW:0] N_ENT = (IW+1)'(pbdt_pkg::TABLE_ENTRIES);

    typedef enum logic [2:0] {S_IDLE, S_PORT, S_SCAN, S_DECIDE, S_RESULT} t_state;

    t_state                r_state;
    pbdt_pkg::t_op         r_op;
    pbdt_pkg::t_key        r_key;
    logic [15:0]           r_handle;
    logic [15:0]           r_assigned;
    logic [IW:0]           r_cnt;
    logic                  r_pend;
    logic [IW-1:0]         r_pend_idx;
    logic [2:0]            r_hit;
    logic [IW-1:0]         r_hit_idx [3];
    logic [15:0]           r_hit_hnd [3];
    logic                  r_free_hit;
    logic [IW-1:0]         r_free_idx;
    logic [pbdt_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [pbdt_pkg::NUM_PROTO-1:0]     r_used;
    logic [2:0]            r_status;
    logic [15:0]           r_found;
    logic                  r_out_valid;
    logic [2:0]            r_out_status;
    logic [15:0]           r_out_found;
    logic [15:0]           r_out_assigned;

    pbdt_pkg::t_key        w_probe [3];
    logic [pbdt_pkg::KV_W-1:0] w_kv_rdata;
    pbdt_pkg::t_key        w_ent_key;
    logic [15:0]           w_ent_hnd;
    logic                  w_ent_vld;
    logic [15:0]           w_port_rdata;
    logic [15:0]           w_assigned;
    logic [15:0]           w_next_port;
    logic                  w_loc_hit;
    logic [IW-1:0]         w_loc_idx;
    logic [15:0]           w_loc_hnd;
    logic                  w_wr_en;
    logic [IW-1:0]         w_wr_idx;
    logic                  w_clr_en;
    logic [IW-1:0]         w_clr_idx;
    logic [2:0]            w_status;
    logic [15:0]           w_found;

    // Three search keys: exact, remote wildcarded, local address wildcarded too.
    always_comb begin
        w_probe[0]       = r_key;
        w_probe[1]       = r_key;
        w_probe[1].rport = i_cfg.wc_port;
        w_probe[1].raddr = i_cfg.wc_addr;
        w_probe[2]       = w_probe[1];
        w_probe[2].laddr = i_cfg.wc_addr;
    end

    assign w_ent_key = pbdt_pkg::t_key'(w_kv_rdata[pbdt_pkg::KV_W-1:16]);
    assign w_ent_hnd = w_kv_rdata[15:0];
    assign w_ent_vld = r_valid[r_pend_idx];

    assign w_assigned  = r_used[r_key.proto] ? w_port_rdata : i_cfg.min_port;
    assign w_next_port = (w_assigned == 16'hFFFF) ? i_cfg.min_port : w_assigned + 16'd1;

    always_comb begin
        if (r_hit[0]) begin
            w_loc_hit = 1'b1;
            w_loc_idx = r_hit_idx[0];
            w_loc_hnd = r_hit_hnd[0];
        end else if (r_hit[1]) begin
            w_loc_hit = 1'b1;
            w_loc_idx = r_hit_idx[1];
            w_loc_hnd = r_hit_hnd[1];
        end else begin
            w_loc_hit = r_hit[2];
            w_loc_idx = r_hit_idx[2];
            w_loc_hnd = r_hit_hnd[2];
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_idx  = r_free_idx;
        w_clr_en  = 1'b0;
        w_clr_idx = w_loc_idx;
        w_status  = pbdt_pkg::ST_OK;
        w_found   = 16'd0;
        if (r_state == S_DECIDE) begin
            unique case (r_op)
                pbdt_pkg::OP_BIND, pbdt_pkg::OP_AUTO: begin
                    if (r_hit[0]) begin
                        w_status = pbdt_pkg::ST_IN_USE;
                    end else if (r_free_hit) begin
                        w_wr_en = 1'b1;
                    end else begin
                        w_status = pbdt_pkg::ST_FULL;
                    end
                end
                pbdt_pkg::OP_REBIND: begin
                    // Keys are unique, so the freed entry or a lower free one takes it.
                    if (!w_loc_hit) begin
                        w_status = pbdt_pkg::ST_NOT_FOUND;
                    end else begin
                        w_clr_en = 1'b1;
                        w_wr_en  = 1'b1;
                        if (!(r_free_hit && r_free_idx < w_loc_idx)) begin
                            w_wr_idx = w_loc_idx;
                        end
                    end
                end
                pbdt_pkg::OP_LOOKUP: begin
                    if (!w_loc_hit) begin
                        w_status = pbdt_pkg::ST_NOT_FOUND;
                    end else begin
                        w_found = w_loc_hnd;
                    end
                end
                pbdt_pkg::OP_UNBIND: begin
                    w_clr_idx = r_hit_idx[0];
                    if (!r_hit[0]) begin
                        w_status = pbdt_pkg::ST_NOT_FOUND;
                    end else if (r_hit_hnd[0] != r_handle) begin
                        w_status = pbdt_pkg::ST_MISMATCH;
                    end else begin
                        w_clr_en = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    pbdt_ram #(.WIDTH(pbdt_pkg::KV_W), .DEPTH(pbdt_pkg::TABLE_ENTRIES)) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_idx),
        .i_wdata ({r_key, r_handle}),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (w_kv_rdata)
    );

    pbdt_ram #(.WIDTH(16), .DEPTH(pbdt_pkg::NUM_PROTO)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PORT),
        .i_waddr (r_key.proto),
        .i_wdata (w_next_port),
        .i_raddr (i_cmd.key.proto),
        .o_rdata (w_port_rdata)
    );

    assign o_cmd_ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.found_handle  = r_out_found;
    assign o_rsp.assigned_port = r_out_assigned;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_hit       <= '0;
            r_free_hit  <= 1'b0;
        end else begin
            // S_RESULT decides the output register on its own
            if (o_rsp.valid && o_rsp.ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op       <= i_cmd.op;
                        r_key      <= i_cmd.key;
                        r_handle   <= i_cmd.handle;
                        r_assigned <= 16'd0;
                        r_hit      <= '0;
                        r_free_hit <= 1'b0;
                        r_cnt      <= '0;
                        r_pend     <= 1'b0;
                        if (i_cmd.op == pbdt_pkg::OP_NONE) begin
                            r_state <= S_DECIDE;
                        end else if (i_cmd.op == pbdt_pkg::OP_AUTO) begin
                            r_state <= S_PORT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_PORT: begin
                    r_key.lport         <= w_assigned;
                    r_key.laddr         <= i_cfg.wc_addr;
                    r_key.rport         <= i_cfg.wc_port;
                    r_key.raddr         <= i_cfg.wc_addr;
                    r_assigned          <= w_assigned;
                    r_used[r_key.proto] <= 1'b1;
                    r_state             <= S_SCAN;
                end
                S_SCAN: begin
                    // Issue one read a cycle; compare the entry read last cycle.
                    r_pend     <= (r_cnt < N_ENT);
                    r_pend_idx <= r_cnt[IW-1:0];
                    if (r_cnt < N_ENT) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_pend) begin
                        for (int j = 0; j < 3; j++) begin
                            if (!r_hit[j] && w_ent_vld && w_ent_key == w_probe[j]) begin
                                r_hit[j]     <= 1'b1;
                                r_hit_idx[j] <= r_pend_idx;
                                r_hit_hnd[j] <= w_ent_hnd;
                            end
                        end
                        if (!r_free_hit && !w_ent_vld) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_pend_idx;
                        end
                    end
                    if (r_cnt == N_ENT && !r_pend) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    // A rebind that reuses its own entry keeps it valid
                    if (w_clr_en && !(w_wr_en && w_wr_idx == w_clr_idx)) begin
                        r_valid[w_clr_idx] <= 1'b0;
                    end
                    if (w_wr_en) begin
                        r_valid[w_wr_idx] <= 1'b1;
                    end
                    r_status <= w_status;
                    r_found  <= w_found;
                    r_state  <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_status   <= r_status;
                        r_out_found    <= r_found;
                        r_out_assigned <= r_assigned;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/port_binding_demux_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_binding_demux_table_unit
// Connection binding table with bind, auto bind, rebind, lookup and unbind.
// ----------------------------------------------------------------------------
// The binding memory has a single read port, and every request with a used
// function code sweeps it one entry per cycle, checking the exact,
// remote-wildcard and local-wildcard keys and the lowest free entry in the
// same pass. A two-deep command queue and an output register let requests
// arrive and results drain while a command executes. Unused function codes
// return ok with zero fields. Configuration is written over APB at byte
// addresses 0, 4 and 8 and must only change while the unit is idle.
module port_binding_demux_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbdt_req_if.sink    i_req,
    pbdt_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    pbdt_pkg::t_cfg r_cfg;
    logic           w_cmd_valid;
    logic           w_cmd_ready;
    pbdt_pkg::t_cmd w_cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_port <= 16'd10000;
            r_cfg.wc_port  <= 16'd0;
            r_cfg.wc_addr  <= 32'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                pbdt_pkg::REG_MIN_PORT: r_cfg.min_port <= pwdata[15:0];
                pbdt_pkg::REG_WC_PORT:  r_cfg.wc_port  <= pwdata[15:0];
                pbdt_pkg::REG_WC_ADDR:  r_cfg.wc_addr  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pbdt_pkg::REG_MIN_PORT: prdata = {16'd0, r_cfg.min_port};
            pbdt_pkg::REG_WC_PORT:  prdata = {16'd0, r_cfg.wc_port};
            pbdt_pkg::REG_WC_ADDR:  prdata = r_cfg.wc_addr;
            default:                prdata = 32'd0;
        endcase
    end

    pbdt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    pbdt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_cfg       (r_cfg),
        .o_rsp       (o_rsp)
    );

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_cmd_valid && !o_rsp.valid)
        else $error("queue or result valid right after reset");

    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && !w_cmd_valid |=> w_cmd_valid)
        else $error("accepted request did not reach the command queue");

    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != pbdt_pkg::ST_OK |-> o_rsp.found_handle == 16'd0)
        else $error("handle reported with a failing status");
endmodule

>>> verif/port_binding_demux_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_binding_demux_table_unit_tb
// Self-checking bench: random and directed binding requests through the
// request channel, results compared against an in-bench table model.
// ----------------------------------------------------------------------------
module port_binding_demux_table_unit_tb;

    typedef struct packed {
        logic [2:0]      func;
        pbdt_pkg::t_key  key;
        logic [15:0]     handle;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found;
        logic [15:0] assigned;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pbdt_req_if req_ch ();
    pbdt_rsp_if rsp_ch ();

    port_binding_demux_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // table model
    logic           tbl_valid  [pbdt_pkg::TABLE_ENTRIES];
    pbdt_pkg::t_key tbl_key    [pbdt_pkg::TABLE_ENTRIES];
    logic [15:0]    tbl_handle [pbdt_pkg::TABLE_ENTRIES];
    logic           port_used  [pbdt_pkg::NUM_PROTO];
    logic [15:0]    port_next  [pbdt_pkg::NUM_PROTO];
    pbdt_pkg::t_cfg cfg;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   mismatches;
    int   send_idle_pct;
    int   recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int find_key(pbdt_pkg::t_key k);
        for (int i = 0; i < pbdt_pkg::TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int search_key(pbdt_pkg::t_key k);
        pbdt_pkg::t_key t;
        int   i;
        t = k;
        i = find_key(t);
        if (i >= 0) return i;
        t.rport = cfg.wc_port;
        t.raddr = cfg.wc_addr;
        i = find_key(t);
        if (i >= 0) return i;
        t.laddr = cfg.wc_addr;
        return find_key(t);
    endfunction

    function automatic logic [2:0] insert_binding(pbdt_pkg::t_key k, logic [15:0] h);
        if (find_key(k) >= 0) return pbdt_pkg::ST_IN_USE;
        for (int i = 0; i < pbdt_pkg::TABLE_ENTRIES; i++)
            if (!tbl_valid[i]) begin
                tbl_valid[i]  = 1'b1;
                tbl_key[i]    = k;
                tbl_handle[i] = h;
                return pbdt_pkg::ST_OK;
            end
        return pbdt_pkg::ST_FULL;
    endfunction

    function automatic t_res predict_binding(t_req r);
        t_res res;
        pbdt_pkg::t_key k;
        int   i;
        res = '0;
        k   = r.key;
        case (r.func)
            pbdt_pkg::FUNC_BIND: res.status = insert_binding(k, r.handle);
            pbdt_pkg::FUNC_AUTO: begin
                if (!port_used[k.proto]) begin
                    port_used[k.proto] = 1'b1;
                    port_next[k.proto] = cfg.min_port;
                end
                res.assigned = port_next[k.proto];
                port_next[k.proto] = (res.assigned == 16'hFFFF) ? cfg.min_port
                                                                : res.assigned + 16'd1;
                k.lport = res.assigned;
                k.laddr = cfg.wc_addr;
                k.rport = cfg.wc_port;
                k.raddr = cfg.wc_addr;
                res.status = insert_binding(k, r.handle);
            end
            pbdt_pkg::FUNC_REBIND: begin
                i = search_key(k);
                if (i < 0) res.status = pbdt_pkg::ST_NOT_FOUND;
                else begin
                    tbl_valid[i] = 1'b0;
                    res.status = insert_binding(k, r.handle);
                end
            end
            pbdt_pkg::FUNC_LOOKUP: begin
                i = search_key(k);
                if (i < 0) res.status = pbdt_pkg::ST_NOT_FOUND;
                else res.found = tbl_handle[i];
            end
            pbdt_pkg::FUNC_UNBIND: begin
                i = find_key(k);
                if (i < 0) res.status = pbdt_pkg::ST_NOT_FOUND;
                else if (tbl_handle[i] != r.handle) res.status = pbdt_pkg::ST_MISMATCH;
                else tbl_valid[i] = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_req r;
                r = pending_reqs.pop_front();
                expected_results.push_back(predict_binding(r));
                req_ch.valid       <= 1'b1;
                req_ch.func        <= r.func;
                req_ch.proto       <= r.key.proto;
                req_ch.lcl_port    <= r.key.lport;
                req_ch.local_addr  <= r.key.laddr;
                req_ch.rmt_port    <= r.key.rport;
                req_ch.remote_addr <= r.key.raddr;
                req_ch.handle      <= r.handle;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'(rsp_ch.status), 32'd0);
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (rsp_ch.status !== e.status)
                        report_mismatch("status", 32'(rsp_ch.status), 32'(e.status));
                    if (rsp_ch.found_handle !== e.found)
                        report_mismatch("found_handle", 32'(rsp_ch.found_handle),
                                        32'(e.found));
                    if (rsp_ch.assigned_port !== e.assigned)
                        report_mismatch("assigned_port", 32'(rsp_ch.assigned_port),
                                        32'(e.assigned));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pbdt_pkg::REG_MIN_PORT: cfg.min_port = value[15:0];
            pbdt_pkg::REG_WC_PORT:  cfg.wc_port  = value[15:0];
            default:                cfg.wc_addr  = value;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || req_ch.valid)
            @(posedge i_clk);
        // cover the command still in flight
        repeat (3 * (pbdt_pkg::TABLE_ENTRIES + 6)) @(posedge i_clk);
    endtask

    function automatic t_req make_req(logic [2:0] f, pbdt_pkg::t_key k, logic [15:0] h);
        t_req r;
        r.func   = f;
        r.key    = k;
        r.handle = h;
        return r;
    endfunction

    // small pools so keys collide and the wildcard steps hit
    function automatic pbdt_pkg::t_key rand_key();
        pbdt_pkg::t_key k;
        k.proto = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
        k.lport = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
        case ($urandom_range(3))
            0: k.laddr = cfg.wc_addr;
            1: k.laddr = $urandom;
            default: k.laddr = 32'($urandom_range(3));
        endcase
        case ($urandom_range(3))
            0: begin k.rport = cfg.wc_port; k.raddr = cfg.wc_addr; end
            1: begin k.rport = 16'($urandom); k.raddr = $urandom; end
            default: begin
                k.rport = 16'($urandom_range(3));
                k.raddr = 32'($urandom_range(3));
            end
        endcase
        return k;
    endfunction

    task automatic queue_random(int count);
        pbdt_pkg::t_key k;
        int   w;
        for (int n = 0; n < count; n++) begin
            k = rand_key();
            w = $urandom_range(99);
            if (w < 25)
                pending_reqs.push_back(make_req(pbdt_pkg::FUNC_BIND, k,
                                                16'($urandom_range(7))));
            else if (w < 35)
                pending_reqs.push_back(make_req(pbdt_pkg::FUNC_AUTO, k, 16'($urandom)));
            else if (w < 50)
                pending_reqs.push_back(make_req(pbdt_pkg::FUNC_REBIND, k,
                                                16'($urandom_range(7))));
            else if (w < 75)
                pending_reqs.push_back(make_req(pbdt_pkg::FUNC_LOOKUP, k, 16'($urandom)));
            else if (w < 97)
                pending_reqs.push_back(make_req(pbdt_pkg::FUNC_UNBIND, k,
                                                16'($urandom_range(7))));
            else
                pending_reqs.push_back(make_req(3'($urandom_range(7, 5)), k,
                                                16'($urandom)));
        end
    endtask

    initial begin
        pbdt_pkg::t_key k;
        mismatches    = 0;
        send_idle_pct = 18;
        recv_idle_pct = 56;
        i_rst_n       = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg.min_port = 16'd10000;
        cfg.wc_port  = '0;
        cfg.wc_addr  = '0;
        for (int i = 0; i < pbdt_pkg::TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < pbdt_pkg::NUM_PROTO; i++) port_used[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wildcard fallback, extremes, mismatch, unused codes
        k = pbdt_pkg::t_key'{8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF};
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_BIND, k, 16'hFFFF));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_BIND, k, 16'h1234));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_LOOKUP, k, 16'h0));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_UNBIND, k, 16'h0));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_UNBIND, k, 16'hFFFF));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_UNBIND, k, 16'hFFFF));
        k = pbdt_pkg::t_key'{8'd6, 16'd80, 32'h0A00_0001, 16'd0, 32'd0};
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_BIND, k, 16'd7));
        k.rport = 16'd5555; k.raddr = 32'hC0A8_0101;
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_LOOKUP, k, 16'd0));
        k.laddr = 32'd0;
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_BIND,
                               pbdt_pkg::t_key'{8'd6, 16'd80, 32'd0, 16'd0, 32'd0},
                               16'd9));
        k.laddr = 32'h0B00_0002;
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_LOOKUP, k, 16'd0));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_REBIND, k, 16'd11));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_LOOKUP, k, 16'd0));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_REBIND,
                               pbdt_pkg::t_key'{8'd1, 16'd1, 32'd1, 16'd1, 32'd1},
                               16'd1));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_AUTO, k, 16'd3));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_AUTO, '0, 16'd4));
        for (int f = 5; f < 8; f++)
            pending_reqs.push_back(make_req(3'(f), k, 16'hFFFF));
        drain();

        // auto bind wrap and reuse of the wrapped ports
        apb_write(pbdt_pkg::REG_MIN_PORT, 32'd65534);
        apb_write(pbdt_pkg::REG_WC_PORT, 32'd65535);
        apb_write(pbdt_pkg::REG_WC_ADDR, 32'hFFFF_FFFF);
        for (int n = 0; n < pbdt_pkg::TABLE_ENTRIES + 4; n++)
            pending_reqs.push_back(make_req(pbdt_pkg::FUNC_AUTO,
                                   pbdt_pkg::t_key'{8'd17, 16'd0, 32'd0, 16'd0, 32'd0},
                                   16'(n)));
        pending_reqs.push_back(make_req(pbdt_pkg::FUNC_BIND,
                               pbdt_pkg::t_key'{8'd9, 16'd9, 32'd9, 16'd9, 32'd9},
                               16'd9));
        queue_random(150);
        drain();
        apb_write(pbdt_pkg::REG_MIN_PORT, 32'd0);
        apb_write(pbdt_pkg::REG_WC_PORT, 32'd0);
        apb_write(pbdt_pkg::REG_WC_ADDR, 32'd0);
        // clear the table through unbinds of known keys
        for (int i = 0; i < pbdt_pkg::TABLE_ENTRIES; i++)
            if (tbl_valid[i])
                pending_reqs.push_back(make_req(pbdt_pkg::FUNC_UNBIND, tbl_key[i],
                                                tbl_handle[i]));
        queue_random(450);
        drain();

        send_idle_pct = 56;
        recv_idle_pct = 18;
        apb_write(pbdt_pkg::REG_MIN_PORT, $urandom);
        apb_write(pbdt_pkg::REG_WC_PORT, 32'($urandom_range(3)));
        apb_write(pbdt_pkg::REG_WC_ADDR, 32'($urandom_range(3)));
        queue_random(550);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(pbdt_pkg::REG_MIN_PORT, 32'd65535);
        apb_write(pbdt_pkg::REG_WC_PORT, 32'd0);
        apb_write(pbdt_pkg::REG_WC_ADDR, 32'd0);
        queue_random(500);
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
